// ===== hdl/qrs_pkg.sv =====
// Shared constants, widths and types of the quadratic root solver.
// No dependencies; every other file of the block refers to this package.
package qrs_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  // Signed discriminant b*b - 4*a*c at full width.
  localparam int DISC_BITS = 2 * WORD_BITS + 2;
  // Magnitude of the discriminant scaled by 2^(2*FRAC_BITS).
  localparam int RAD_BITS  = 2 * WORD_BITS + 1 + 2 * FRAC_BITS;
  localparam int ROOT_BITS = (RAD_BITS + 1) / 2;
  localparam int SCALED_BITS = WORD_BITS + FRAC_BITS;
  // Magnitude of a divider numerator.
  localparam int NUM_BITS  =
      ((SCALED_BITS > ROOT_BITS) ? SCALED_BITS : ROOT_BITS) + 1;
  // Magnitude of a divider denominator, up to 2*|a|.
  localparam int DEN_BITS  = WORD_BITS + 1;
  // Quotient bits developed before saturation.
  localparam int QUO_BITS  = WORD_BITS + 1;
  localparam int NUM_LANES = 2;

  typedef enum logic [2:0] {
    KIND_LINEAR   = 3'd0,
    KIND_TWO_REAL = 3'd1,
    KIND_DOUBLE   = 3'd2,
    KIND_COMPLEX  = 3'd3,
    KIND_NONE     = 3'd4
  } kind_e;

  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef struct packed {
    kind_e kind;
    word_t a;
    word_t b;
    word_t c;
  } sq_side_t;

  typedef struct packed {
    kind_e                kind;
    logic [NUM_LANES-1:0] neg;
  } dv_side_t;

endpackage

// ===== hdl/qrs_if.sv =====
// Handshake channels of the quadratic root solver: coefficients in, roots out.
// Depends on qrs_pkg for the word width.
interface qrs_coef_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [qrs_pkg::WORD_BITS-1:0] coef_quadratic;
  logic signed [qrs_pkg::WORD_BITS-1:0] coef_linear;
  logic signed [qrs_pkg::WORD_BITS-1:0] coef_constant;

  modport source (output valid, coef_quadratic, coef_linear, coef_constant, input ready);
  modport sink (input valid, coef_quadratic, coef_linear, coef_constant, output ready);
endinterface

interface qrs_root_if;
  logic                                 valid;
  logic                                 ready;
  logic [2:0]                           root_kind;
  logic signed [qrs_pkg::WORD_BITS-1:0] first_value;
  logic signed [qrs_pkg::WORD_BITS-1:0] second_value;
  logic                                 saturated;

  modport source (output valid, root_kind, first_value, second_value, saturated,
                  input ready);
  modport sink (input valid, root_kind, first_value, second_value, saturated,
                output ready);
endinterface

// ===== hdl/quadratic_root_solver.sv =====
// Top level of the quadratic root solver: products, discriminant, root and
// divider pipelines, saturation. Depends on qrs_pkg, qrs_if, qrs_sqrt, qrs_div.
//
// Usage: coefficients a, b, c (signed Q16.16) arrive on coef_i; one transfer
// on root_o carries the kind of solution, the two values and a clip flag.
// Two real roots give (-b+sqrt(D))/2a and (-b-sqrt(D))/2a, a double root
// gives -b/2a, a complex pair gives the real part and the imaginary
// magnitude, a zero quadratic term gives -c/b, and a and b both zero give
// the no-solution kind with all values zero.
// The square root develops one of its 49 bits per stage and the two-lane
// divider one of its 33 quotient bits per stage.
// Throughput is one transfer per cycle while root_o is not stalled; every stage advances together.
// When root_o is stalled, the whole pipeline holds and coef_i.ready drops in
// the same cycle, so nothing is lost or repeated; ready returns as soon as
// the output transfer completes.
// Reset clears all valid bits; the pipeline is empty and ready right after.
module quadratic_root_solver (
  input logic        clk_i,
  input logic        rst_ni,
  qrs_coef_if.sink   coef_i,
  qrs_root_if.source root_o
);

  localparam int W   = qrs_pkg::WORD_BITS;
  localparam int F   = qrs_pkg::FRAC_BITS;
  localparam int DB  = qrs_pkg::DISC_BITS;
  localparam int NW  = qrs_pkg::NUM_BITS;
  localparam int NSW = qrs_pkg::NUM_BITS + 1;
  localparam int DNW = qrs_pkg::DEN_BITS;
  localparam int DSW = qrs_pkg::WORD_BITS + 2;
  localparam int QB  = qrs_pkg::QUO_BITS;
  localparam int NL  = qrs_pkg::NUM_LANES;

  logic adv;
  logic out_valid_q;

  assign adv          = !out_valid_q || root_o.ready;
  assign coef_i.ready = adv;

  // Input stage: coefficients and their magnitudes.
  logic           s0_valid_q;
  qrs_pkg::word_t s0_a_q, s0_b_q, s0_c_q;
  logic [W-1:0]   s0_am_q, s0_bm_q, s0_cm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (adv) begin
      s0_valid_q <= coef_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_a_q  <= coef_i.coef_quadratic;
      s0_b_q  <= coef_i.coef_linear;
      s0_c_q  <= coef_i.coef_constant;
      s0_am_q <= coef_i.coef_quadratic[W-1] ? -coef_i.coef_quadratic : coef_i.coef_quadratic;
      s0_bm_q <= coef_i.coef_linear[W-1] ? -coef_i.coef_linear : coef_i.coef_linear;
      s0_cm_q <= coef_i.coef_constant[W-1] ? -coef_i.coef_constant : coef_i.coef_constant;
    end
  end

  // Product stage.
  logic           s1_valid_q;
  qrs_pkg::word_t s1_a_q, s1_b_q, s1_c_q;
  logic [2*W-1:0] s1_bb_q, s1_ac_q;
  logic           s1_acn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_a_q   <= s0_a_q;
      s1_b_q   <= s0_b_q;
      s1_c_q   <= s0_c_q;
      s1_bb_q  <= s0_bm_q * s0_bm_q;
      s1_ac_q  <= s0_am_q * s0_cm_q;
      s1_acn_q <= s0_a_q[W-1] ^ s0_c_q[W-1];
    end
  end

  // Discriminant stage.
  logic           s2_valid_q;
  qrs_pkg::word_t s2_a_q, s2_b_q, s2_c_q;
  logic [DB-1:0]  s2_disc_q;
  logic [DB-1:0]  bb_ext, ac4_ext;

  always_comb begin
    bb_ext  = DB'(s1_bb_q);
    ac4_ext = DB'(s1_ac_q) << 2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_a_q    <= s1_a_q;
      s2_b_q    <= s1_b_q;
      s2_c_q    <= s1_c_q;
      s2_disc_q <= s1_acn_q ? (bb_ext + ac4_ext) : (bb_ext - ac4_ext);
    end
  end

  // Classification and radicand.
  logic [DB-1:0]                  disc_abs;
  logic [qrs_pkg::RAD_BITS-1:0]   rad;
  qrs_pkg::sq_side_t              sq_in;

  always_comb begin
    disc_abs = s2_disc_q[DB-1] ? -s2_disc_q : s2_disc_q;
    rad      = {disc_abs[DB-2:0], {(2 * F){1'b0}}};
    sq_in.a  = s2_a_q;
    sq_in.b  = s2_b_q;
    sq_in.c  = s2_c_q;
    if (s2_a_q == '0) begin
      sq_in.kind = (s2_b_q == '0) ? qrs_pkg::KIND_NONE : qrs_pkg::KIND_LINEAR;
    end else if (s2_disc_q == '0) begin
      sq_in.kind = qrs_pkg::KIND_DOUBLE;
    end else if (s2_disc_q[DB-1]) begin
      sq_in.kind = qrs_pkg::KIND_COMPLEX;
    end else begin
      sq_in.kind = qrs_pkg::KIND_TWO_REAL;
    end
  end

  logic                          sq_valid;
  logic [qrs_pkg::ROOT_BITS-1:0] sq_root;
  qrs_pkg::sq_side_t             sq_side;

  qrs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s2_valid_q),
    .rad_i   (rad),
    .side_i  (sq_in),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // Numerator and denominator selection, signed.
  logic                  f1_valid_q;
  qrs_pkg::kind_e        f1_kind_q;
  logic signed [NSW-1:0] f1_num_q [NL];
  logic signed [DSW-1:0] f1_den_q [NL];
  logic signed [NSW-1:0] bs, cs, rt;
  logic signed [DSW-1:0] a2, a2m, bx;
  logic signed [NSW-1:0] num_d [NL];
  logic signed [DSW-1:0] den_d [NL];

  always_comb begin
    bs  = -(NSW'($signed(sq_side.b)) <<< F);
    cs  = -(NSW'($signed(sq_side.c)) <<< F);
    rt  = NSW'(sq_root);
    a2  = DSW'($signed(sq_side.a)) <<< 1;
    a2m = a2[DSW-1] ? -a2 : a2;
    bx  = DSW'($signed(sq_side.b));
    num_d[0] = bs;
    den_d[0] = a2;
    num_d[1] = '0;
    den_d[1] = DSW'(1);
    case (sq_side.kind)
      qrs_pkg::KIND_LINEAR: begin
        num_d[0] = cs;
        den_d[0] = bx;
      end
      qrs_pkg::KIND_TWO_REAL: begin
        num_d[0] = bs + rt;
        num_d[1] = bs - rt;
        den_d[1] = a2;
      end
      qrs_pkg::KIND_COMPLEX: begin
        num_d[1] = rt;
        den_d[1] = a2m;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
    end else if (adv) begin
      f1_valid_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f1_kind_q <= sq_side.kind;
      f1_num_q  <= num_d;
      f1_den_q  <= den_d;
    end
  end

  // Magnitudes and quotient signs.
  logic              f2_valid_q;
  qrs_pkg::dv_side_t f2_side_q;
  logic [NW-1:0]     f2_num_q [NL];
  logic [DNW-1:0]    f2_den_q [NL];
  logic [NSW-1:0]    num_abs  [NL];
  logic [DSW-1:0]    den_abs  [NL];
  logic [NL-1:0]     neg_d;

  for (genvar l = 0; l < NL; l++) begin : g_abs
    assign num_abs[l] = f1_num_q[l][NSW-1] ? -f1_num_q[l] : f1_num_q[l];
    assign den_abs[l] = f1_den_q[l][DSW-1] ? -f1_den_q[l] : f1_den_q[l];
    assign neg_d[l]   = f1_num_q[l][NSW-1] ^ f1_den_q[l][DSW-1];

    always_ff @(posedge clk_i) begin
      if (adv) begin
        f2_num_q[l] <= num_abs[l][NW-1:0];
        f2_den_q[l] <= den_abs[l][DNW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f2_valid_q <= 1'b0;
    end else if (adv) begin
      f2_valid_q <= f1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f2_side_q.kind <= f1_kind_q;
      f2_side_q.neg  <= neg_d;
    end
  end

  logic              dv_valid;
  logic [QB-1:0]     dv_quo [NL];
  logic              dv_ovf [NL];
  qrs_pkg::dv_side_t dv_side;

  qrs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (f2_valid_q),
    .num_i   (f2_num_q),
    .den_i   (f2_den_q),
    .side_i  (f2_side_q),
    .valid_o (dv_valid),
    .quo_o   (dv_quo),
    .ovf_o   (dv_ovf),
    .side_o  (dv_side)
  );

  // Saturation and output register.
  localparam logic [QB-1:0] LIM_POS = {2'b00, {(W - 1){1'b1}}};
  localparam logic [QB-1:0] LIM_NEG = {2'b01, {(W - 1){1'b0}}};

  logic [W-1:0] lane_val  [NL];
  logic         lane_clip [NL];

  for (genvar l = 0; l < NL; l++) begin : g_sat
    logic [QB-1:0] lim;
    logic [QB-1:0] mag;

    always_comb begin
      lim          = dv_side.neg[l] ? LIM_NEG : LIM_POS;
      lane_clip[l] = dv_ovf[l] || (dv_quo[l] > lim);
      mag          = lane_clip[l] ? lim : dv_quo[l];
      lane_val[l]  = dv_side.neg[l] ? -mag[W-1:0] : mag[W-1:0];
    end
  end

  logic           use_second;
  logic           out_none;
  logic [2:0]     out_kind_q;
  qrs_pkg::word_t out_first_q, out_second_q;
  logic           out_sat_q;

  assign use_second = (dv_side.kind == qrs_pkg::KIND_TWO_REAL) ||
                      (dv_side.kind == qrs_pkg::KIND_COMPLEX);
  assign out_none   = (dv_side.kind == qrs_pkg::KIND_NONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_kind_q   <= dv_side.kind;
      out_first_q  <= out_none ? '0 : lane_val[0];
      out_second_q <= (use_second && !out_none) ? lane_val[1] : '0;
      out_sat_q    <= !out_none && (lane_clip[0] || (use_second && lane_clip[1]));
    end
  end

  assign root_o.valid        = out_valid_q;
  assign root_o.root_kind    = out_kind_q;
  assign root_o.first_value  = out_first_q;
  assign root_o.second_value = out_second_q;
  assign root_o.saturated    = out_sat_q;

  a_none_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == qrs_pkg::KIND_NONE) |->
      (out_first_q == '0 && out_second_q == '0 && !out_sat_q))
    else $error("no-solution result carries nonzero values");

  a_single_second : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_kind_q == qrs_pkg::KIND_LINEAR ||
                     out_kind_q == qrs_pkg::KIND_DOUBLE)) |-> (out_second_q == '0))
    else $error("single-valued result has a nonzero second value");

  a_imag_sign : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == qrs_pkg::KIND_COMPLEX) |-> !out_second_q[W-1])
    else $error("imaginary magnitude is negative");

  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!adv) |=> ($stable(s2_disc_q) && $stable(f1_kind_q) && out_valid_q))
    else $error("pipeline moved while the output was stalled");

endmodule

// ===== hdl/qrs_sqrt.sv =====
// Pipelined integer square root, one root bit per register stage.
// Carries a side payload with each item; depends on qrs_pkg.
module qrs_sqrt (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [qrs_pkg::RAD_BITS-1:0]    rad_i,
  input  qrs_pkg::sq_side_t               side_i,
  output logic                            valid_o,
  output logic [qrs_pkg::ROOT_BITS-1:0]   root_o,
  output qrs_pkg::sq_side_t               side_o
);

  localparam int RW = qrs_pkg::RAD_BITS;
  localparam int QW = qrs_pkg::ROOT_BITS;

  logic              valid_q [0:QW];
  logic [RW-1:0]     rem_q   [0:QW];
  logic [QW-1:0]     root_q  [0:QW];
  qrs_pkg::sq_side_t side_q  [0:QW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= rad_i;
      root_q[0] <= '0;
      side_q[0] <= side_i;
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int K = QW - 1 - s;
    logic [RW-1:0] trial;
    logic          fit;

    always_comb begin
      trial = (RW'(root_q[s]) << (K + 1)) | (RW'(1) << (2 * K));
      fit   = (rem_q[s] >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s+1] <= 1'b0;
      end else if (en_i) begin
        valid_q[s+1] <= valid_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= fit ? (rem_q[s] - trial) : rem_q[s];
        root_q[s+1] <= root_q[s] | (fit ? (QW'(1) << K) : '0);
        side_q[s+1] <= side_q[s];
      end
    end
  end

  assign valid_o = valid_q[QW];
  assign root_o  = root_q[QW];
  assign side_o  = side_q[QW];

endmodule

// ===== hdl/qrs_div.sv =====
// Two-lane pipelined restoring divider, one quotient bit per register stage,
// with an overflow flag for quotients beyond the developed bits; uses qrs_pkg.
module qrs_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [qrs_pkg::NUM_BITS-1:0]  num_i [qrs_pkg::NUM_LANES],
  input  logic [qrs_pkg::DEN_BITS-1:0]  den_i [qrs_pkg::NUM_LANES],
  input  qrs_pkg::dv_side_t             side_i,
  output logic                          valid_o,
  output logic [qrs_pkg::QUO_BITS-1:0]  quo_o [qrs_pkg::NUM_LANES],
  output logic                          ovf_o [qrs_pkg::NUM_LANES],
  output qrs_pkg::dv_side_t             side_o
);

  localparam int NW = qrs_pkg::NUM_BITS;
  localparam int DW = qrs_pkg::DEN_BITS;
  localparam int QB = qrs_pkg::QUO_BITS;
  localparam int NL = qrs_pkg::NUM_LANES;
  localparam int HW = NW - QB;
  localparam int CW = (HW > DW) ? HW : DW;

  logic              valid_q [0:QB];
  qrs_pkg::dv_side_t side_q  [0:QB];
  logic [DW-1:0]     rem_q   [0:QB][NL];
  logic [DW-1:0]     den_q   [0:QB][NL];
  logic [QB-1:0]     low_q   [0:QB][NL];
  logic [QB-1:0]     quo_q   [0:QB][NL];
  logic              ovf_q   [0:QB][NL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
    end
  end

  for (genvar l = 0; l < NL; l++) begin : g_init
    logic [CW-1:0] hi_ext;
    logic [CW-1:0] den_ext;

    always_comb begin
      hi_ext  = CW'(num_i[l][NW-1:QB]);
      den_ext = CW'(den_i[l]);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[0][l] <= hi_ext[DW-1:0];
        den_q[0][l] <= den_i[l];
        low_q[0][l] <= num_i[l][QB-1:0];
        quo_q[0][l] <= '0;
        ovf_q[0][l] <= (hi_ext >= den_ext);
      end
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s+1] <= 1'b0;
      end else if (en_i) begin
        valid_q[s+1] <= valid_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[s+1] <= side_q[s];
      end
    end

    for (genvar l = 0; l < NL; l++) begin : g_lane
      logic [DW:0] shifted;
      logic [DW:0] diff;
      logic        fit;

      always_comb begin
        shifted = {rem_q[s][l], low_q[s][l][QB-1]};
        diff    = shifted - {1'b0, den_q[s][l]};
        fit     = (shifted >= {1'b0, den_q[s][l]});
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s+1][l] <= fit ? diff[DW-1:0] : shifted[DW-1:0];
          den_q[s+1][l] <= den_q[s][l];
          low_q[s+1][l] <= {low_q[s][l][QB-2:0], 1'b0};
          quo_q[s+1][l] <= {quo_q[s][l][QB-2:0], fit};
          ovf_q[s+1][l] <= ovf_q[s][l];
        end
      end
    end
  end

  for (genvar l = 0; l < NL; l++) begin : g_out
    assign quo_o[l] = quo_q[QB][l];
    assign ovf_o[l] = ovf_q[QB][l];
  end

  assign valid_o = valid_q[QB];
  assign side_o  = side_q[QB];

endmodule

// ===== bench/quadratic_root_solver_test.sv =====
// Self-checking testbench of the quadratic root solver: directed and random
// coefficient sets, with a scoreboard that predicts each root transfer.
// Depends on qrs_pkg, qrs_if and the solver RTL.
module quadratic_root_solver_test;

  typedef struct {
    qrs_pkg::kind_e kind;
    qrs_pkg::word_t first;
    qrs_pkg::word_t second;
    logic           sat;
  } roots_t;

  class root_scoreboard;
    roots_t pending[$];
    int     mismatches;
    int     checked;
    int     kind_seen[5];

    // Saturates a signed wide value to a word and notes clipping.
    function qrs_pkg::word_t clip(logic signed [127:0] v, ref logic sat);
      logic signed [127:0] hi;
      logic signed [127:0] lo;
      hi = (128'sd1 <<< (qrs_pkg::WORD_BITS - 1)) - 1;
      lo = -(128'sd1 <<< (qrs_pkg::WORD_BITS - 1));
      if (v > hi) begin
        sat = 1'b1;
        return hi[qrs_pkg::WORD_BITS-1:0];
      end
      if (v < lo) begin
        sat = 1'b1;
        return lo[qrs_pkg::WORD_BITS-1:0];
      end
      return v[qrs_pkg::WORD_BITS-1:0];
    endfunction

    function logic [127:0] isqrt(logic [127:0] n);
      logic [127:0] r;
      logic [127:0] c;
      r = 0;
      for (int i = 63; i >= 0; i--) begin
        c = r | (128'd1 << i);
        if (c * c <= n) r = c;
      end
      return r;
    endfunction

    function void note_coefs(qrs_pkg::word_t a, qrs_pkg::word_t b, qrs_pkg::word_t c);
      roots_t              e;
      logic signed [127:0] sa, sb, sc, d, num, den, rt, s;
      s = 128'sd1 <<< qrs_pkg::FRAC_BITS;
      sa = a;
      sb = b;
      sc = c;
      e.first = '0;
      e.second = '0;
      e.sat = 1'b0;
      if (a == 0 && b == 0) begin
        e.kind = qrs_pkg::KIND_NONE;
      end else if (a == 0) begin
        e.kind = qrs_pkg::KIND_LINEAR;
        e.first = clip(-sc * s / sb, e.sat);
      end else begin
        d = sb * sb - 4 * sa * sc;
        num = -sb * s;
        den = 2 * sa;
        if (d == 0) begin
          e.kind = qrs_pkg::KIND_DOUBLE;
          e.first = clip(num / den, e.sat);
        end else begin
          rt = $signed(isqrt((d < 0 ? -d : d) * s * s));
          if (d > 0) begin
            e.kind = qrs_pkg::KIND_TWO_REAL;
            e.first = clip((num + rt) / den, e.sat);
            e.second = clip((num - rt) / den, e.sat);
          end else begin
            e.kind = qrs_pkg::KIND_COMPLEX;
            e.first = clip(num / den, e.sat);
            e.second = clip(rt / (den < 0 ? -den : den), e.sat);
          end
        end
      end
      kind_seen[e.kind]++;
      pending.push_back(e);
    endfunction

    function void check_roots(logic [2:0] kind, qrs_pkg::word_t first,
                              qrs_pkg::word_t second, logic sat);
      roots_t e;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected root transfer, kind %0d", kind);
        return;
      end
      e = pending.pop_front();
      if (kind !== e.kind || first !== e.first || second !== e.second || sat !== e.sat) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                   e.kind, e.first, e.second, e.sat, kind, first, second, sat);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   cycles = 0;
  root_scoreboard board = new();

  qrs_coef_if coef_ch ();
  qrs_root_if root_ch ();

  quadratic_root_solver DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .coef_i (coef_ch),
    .root_o (root_ch)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Timeout with %0d transfers outstanding", board.pending.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (coef_ch.valid && coef_ch.ready)
      board.note_coefs(coef_ch.coef_quadratic, coef_ch.coef_linear, coef_ch.coef_constant);
    if (root_ch.valid && root_ch.ready)
      board.check_roots(root_ch.root_kind, root_ch.first_value, root_ch.second_value,
                        root_ch.saturated);
  end

  function automatic qrs_pkg::word_t pick_coef();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return qrs_pkg::word_t'($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000);
      2: return qrs_pkg::word_t'($signed($urandom_range(0, 8)) - 4) <<< qrs_pkg::FRAC_BITS;
      3: return qrs_pkg::word_t'($signed($urandom_range(0, 65535)) - 32768);
      4: return qrs_pkg::word_t'($urandom_range(0, 1) ? 32'h00000001 : 32'hffffffff);
      default: return qrs_pkg::word_t'($urandom());
    endcase
  endfunction

  task automatic send_coefs(qrs_pkg::word_t a, qrs_pkg::word_t b, qrs_pkg::word_t c);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      coef_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    coef_ch.valid <= 1'b1;
    coef_ch.coef_quadratic <= a;
    coef_ch.coef_linear <= b;
    coef_ch.coef_constant <= c;
    @(posedge clk_i);
    while (!coef_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    int n;
    root_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (root_ch.ready && root_ch.valid || !root_ch.ready) begin
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
        if (n > 0) begin
          root_ch.ready <= 1'b0;
          repeat (n) @(negedge clk_i);
        end
        root_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    qrs_pkg::word_t a;
    qrs_pkg::word_t b;
    qrs_pkg::word_t c;
    int             k;
    coef_ch.valid = 1'b0;
    coef_ch.coef_quadratic = '0;
    coef_ch.coef_linear = '0;
    coef_ch.coef_constant = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    send_coefs(0, 0, 0);
    send_coefs(0, 0, 32'sh7fffffff);
    send_coefs(0, 32'sh00010000, 32'sh00020000);
    send_coefs(0, 32'sh00000001, 32'sh7fffffff);
    send_coefs(0, 32'sh80000000, 32'sh80000000);
    send_coefs(32'sh00010000, 32'shfffd0000, 32'sh00020000);
    send_coefs(32'sh00010000, 32'sh00020000, 32'sh00010000);
    send_coefs(32'sh00010000, 0, 32'sh00010000);
    send_coefs(32'shffff0000, 32'sh00020000, 32'shffff0000);
    send_coefs(32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_coefs(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    send_coefs(32'sh00000001, 32'sh80000000, 32'sh7fffffff);
    send_coefs(32'sh00000001, 32'sh00000002, 32'sh00000001);
    send_coefs(32'sh80000000, 0, 32'sh7fffffff);
    send_coefs(32'shffffffff, 32'sh7fffffff, 0);
    send_coefs(32'sh00010000, 0, 0);
    for (int i = 0; i < 1950; i++) begin
      a = pick_coef();
      b = pick_coef();
      c = pick_coef();
      if ($urandom_range(0, 4) == 0) begin
        // Force a double root: with a of one raw unit, b = 2k and c = k*k.
        k = $urandom_range(0, 2000);
        a = 1;
        b = qrs_pkg::word_t'(2 * k);
        c = qrs_pkg::word_t'(k * k);
      end
      send_coefs(a, b, c);
    end
    coef_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
    $display("Checked %0d root transfers: linear %0d, two real %0d, double %0d,",
             board.checked, board.kind_seen[0], board.kind_seen[1], board.kind_seen[2]);
    $display("complex %0d, no solution %0d.", board.kind_seen[3], board.kind_seen[4]);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
